>>> rtl/wlan_retry_and_backoff_window_core_macros.svh
// ----------------------------------------------------------------------------
// retry and backoff window core - assertion macros
// shared concurrent assertion forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef WLAN_RETRY_AND_BACKOFF_WINDOW_CORE_MACROS_SVH
`define WLAN_RETRY_AND_BACKOFF_WINDOW_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define WRBW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WRBW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wrbw_pkg.sv
// ----------------------------------------------------------------------------
// wrbw_pkg
// shared constants, types and helpers of the retry and backoff window core
// ----------------------------------------------------------------------------
package wrbw_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 32;
    localparam int ID_BITS       = 32;
    // only the low KEY_W bits of the frame id take part in the compare (all 32 at present)
    localparam int KEY_W         = (KEY_BITS < ID_BITS) ? KEY_BITS : ID_BITS;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW_BITS       = 10;
    localparam int CNT_BITS      = 8;
    localparam int LEN_BITS      = 16;
    localparam int OP_BITS       = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CW_BITS-1:0]  WINDOW_MIN_RST    = CW_BITS'(15);
    localparam logic [CW_BITS-1:0]  WINDOW_MAX_RST    = CW_BITS'(1023);
    localparam logic [CNT_BITS-1:0] SHORT_LIMIT_RST   = CNT_BITS'(7);
    localparam logic [CNT_BITS-1:0] LONG_LIMIT_RST    = CNT_BITS'(4);
    localparam logic [LEN_BITS-1:0] RTS_THRESHOLD_RST = LEN_BITS'(2347);
    localparam logic [CNT_BITS-1:0] CNT_MAX           = {CNT_BITS{1'b1}};

    typedef enum logic [OP_BITS-1:0] {
        OP_CTS_RX     = 3'd0,
        OP_BACK_RX    = 3'd1,
        OP_ACK_RX     = 3'd2,
        OP_GROUP_TX   = 3'd3,
        OP_DATA_FAIL  = 3'd4,
        OP_RTS_FAIL   = 3'd5,
        OP_DATA_QUERY = 3'd6,
        OP_RTS_QUERY  = 3'd7
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_MIN    = 3'd0,
        REG_WINDOW_MAX    = 3'd1,
        REG_SHORT_LIMIT   = 3'd2,
        REG_LONG_LIMIT    = 3'd3,
        REG_RTS_THRESHOLD = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CW_BITS-1:0]  window_min;
        logic [CW_BITS-1:0]  window_max;
        logic [CNT_BITS-1:0] short_limit;
        logic [CNT_BITS-1:0] long_limit;
        logic [LEN_BITS-1:0] rts_threshold;
    } cfg_t;

    typedef struct packed {
        logic             fire;
        op_t              op;
        logic             is_long;
        logic [KEY_W-1:0] key;
    } tbl_req_t;

    typedef struct packed {
        logic limit_reached;
        logic entry_missing;
        logic table_full;
    } tbl_rsp_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_BITS'(1);
    endfunction

endpackage

>>> rtl/wrbw_cfg.sv
// ----------------------------------------------------------------------------
// wrbw_cfg
// configuration register file, written through an always-ready port
// ----------------------------------------------------------------------------
module wrbw_cfg
    import wrbw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_MIN:    cfg_next.window_min    = cfg_data[CW_BITS-1:0];
                REG_WINDOW_MAX:    cfg_next.window_max    = cfg_data[CW_BITS-1:0];
                REG_SHORT_LIMIT:   cfg_next.short_limit   = cfg_data[CNT_BITS-1:0];
                REG_LONG_LIMIT:    cfg_next.long_limit    = cfg_data[CNT_BITS-1:0];
                REG_RTS_THRESHOLD: cfg_next.rts_threshold = cfg_data[LEN_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_min    <= WINDOW_MIN_RST;
            cfg_reg.window_max    <= WINDOW_MAX_RST;
            cfg_reg.short_limit   <= SHORT_LIMIT_RST;
            cfg_reg.long_limit    <= LONG_LIMIT_RST;
            cfg_reg.rts_threshold <= RTS_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/wrbw_station.sv
// ----------------------------------------------------------------------------
// wrbw_station
// station short and long retry counts and the contention window
// ----------------------------------------------------------------------------
`include "wlan_retry_and_backoff_window_core_macros.svh"

module wrbw_station
    import wrbw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                fire,
    input  op_t                 op,
    input  logic                is_long,
    output logic [CW_BITS-1:0]  window_after,
    output logic [CNT_BITS-1:0] short_after,
    output logic [CNT_BITS-1:0] long_after
);

    logic [CW_BITS-1:0]  window_reg;
    logic [CW_BITS-1:0]  window_next;
    logic [CNT_BITS-1:0] short_reg;
    logic [CNT_BITS-1:0] short_next;
    logic [CNT_BITS-1:0] long_reg;
    logic [CNT_BITS-1:0] long_next;
    logic [CW_BITS:0]    doubled;
    logic [CW_BITS-1:0]  grown;

    // 2w+1 clipped at the ceiling
    assign doubled = {window_reg, 1'b1};
    assign grown   = (doubled > {1'b0, cfg.window_max}) ? cfg.window_max
                                                        : doubled[CW_BITS-1:0];

    always_comb
    begin
        window_next = window_reg;
        short_next  = short_reg;
        long_next   = long_reg;
        case (op)
            OP_CTS_RX,
            OP_BACK_RX:
            begin
                short_next = '0;
            end
            OP_ACK_RX:
            begin
                if (is_long)
                    long_next = '0;
                else
                    short_next = '0;
                window_next = cfg.window_min;
            end
            OP_GROUP_TX:
            begin
                short_next = '0;
                long_next  = '0;
            end
            OP_DATA_FAIL:
            begin
                if (is_long)
                begin
                    long_next   = sat_inc(long_reg);
                    window_next = (long_next == cfg.long_limit) ? cfg.window_min : grown;
                end
                else
                begin
                    short_next  = sat_inc(short_reg);
                    window_next = (short_next == cfg.short_limit) ? cfg.window_min : grown;
                end
            end
            OP_RTS_FAIL:
            begin
                short_next  = sat_inc(short_reg);
                window_next = (short_next == cfg.short_limit) ? cfg.window_min : grown;
            end
            default:
            begin
                window_next = window_reg;
            end
        endcase
    end

    assign window_after = window_next;
    assign short_after  = short_next;
    assign long_after   = long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_MIN_RST;
            short_reg  <= '0;
            long_reg   <= '0;
        end
        else if (fire)
        begin
            window_reg <= window_next;
            short_reg  <= short_next;
            long_reg   <= long_next;
        end
    end

    `WRBW_ASSERT_NEXT(a_ack_resets_window, fire && (op == OP_ACK_RX), window_reg == $past(cfg.window_min), "ack did not reset the window")
    `WRBW_ASSERT_NEXT(a_group_clears_counts, fire && (op == OP_GROUP_TX), (short_reg == '0) && (long_reg == '0), "group word left station counts")

endmodule

>>> rtl/wrbw_table.sv
// ----------------------------------------------------------------------------
// wrbw_table
// keyed per-frame retry count table with parallel key compare
// ----------------------------------------------------------------------------
`include "wlan_retry_and_backoff_window_core_macros.svh"

module wrbw_table
    import wrbw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  tbl_req_t req,
    output tbl_rsp_t rsp
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [KEY_W-1:0]         key_reg   [TABLE_ENTRIES];
    logic [CNT_BITS-1:0]      short_reg [TABLE_ENTRIES];
    logic [CNT_BITS-1:0]      long_reg  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic                     hit;
    logic [IDX_BITS-1:0]      hit_idx;
    logic                     has_free;
    logic [IDX_BITS-1:0]      free_idx;
    logic                     is_fail;
    logic                     count_long;
    logic                     do_wr;
    logic [IDX_BITS-1:0]      wr_idx;
    logic [CNT_BITS-1:0]      base_short;
    logic [CNT_BITS-1:0]      base_long;
    logic [CNT_BITS-1:0]      wr_short;
    logic [CNT_BITS-1:0]      wr_long;
    logic                     use_long;
    logic [CNT_BITS-1:0]      query_cnt;
    logic [CNT_BITS-1:0]      query_lim;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
    end

    // lowest matching entry and lowest free entry
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = IDX_BITS'(i);
            if (!valid_reg[i])
                free_idx = IDX_BITS'(i);
        end
    end

    assign hit      = |hit_vec;
    assign has_free = ~&valid_reg;

    assign is_fail    = (req.op == OP_DATA_FAIL) || (req.op == OP_RTS_FAIL);
    assign count_long = (req.op == OP_DATA_FAIL) && req.is_long;
    assign do_wr      = req.fire && is_fail && (hit || has_free);
    assign wr_idx     = hit ? hit_idx : free_idx;

    // a fresh entry starts from zero in both counts
    assign base_short = hit ? short_reg[hit_idx] : '0;
    assign base_long  = hit ? long_reg[hit_idx]  : '0;
    assign wr_short   = count_long ? base_short : sat_inc(base_short);
    assign wr_long    = count_long ? sat_inc(base_long) : base_long;

    assign use_long  = (req.op == OP_DATA_QUERY) && req.is_long;
    assign query_cnt = hit ? (use_long ? long_reg[hit_idx] : short_reg[hit_idx]) : '0;
    assign query_lim = use_long ? cfg.long_limit : cfg.short_limit;

    always_comb
    begin
        rsp = '0;
        case (req.op)
            OP_DATA_FAIL,
            OP_RTS_FAIL:
            begin
                rsp.table_full = !hit && !has_free;
            end
            OP_DATA_QUERY,
            OP_RTS_QUERY:
            begin
                rsp.entry_missing = (query_cnt == '0);
                rsp.limit_reached = (query_cnt != '0) && (query_cnt >= query_lim);
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (do_wr)
            valid_next[wr_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            key_reg[wr_idx]   <= req.key;
            short_reg[wr_idx] <= wr_short;
            long_reg[wr_idx]  <= wr_long;
        end
    end

    `WRBW_ASSERT_NOW(a_key_unique, 1'b1, $onehot0(hit_vec), "frame key held in more than one entry")
    `WRBW_ASSERT_NOW(a_full_only_packed, rsp.table_full, (&valid_reg) && is_fail, "full flagged with room left")
    `WRBW_ASSERT_NEXT(a_alloc_sets_valid, req.fire && is_fail && !hit && has_free, valid_reg[$past(free_idx)], "new key not allocated")

endmodule

>>> rtl/wlan_retry_and_backoff_window_core.sv
// ----------------------------------------------------------------------------
// wlan_retry_and_backoff_window_core
// retry counters and contention window of a wireless mac station
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall) carries one mac event word:
//   opcode, frame_id and frame_length. result channel (result_valid /
//   result_stall) returns exactly one word per event with the window,
//   station counts and the per-frame query / table flags.
//   the cfg channel (cfg_valid / cfg_ready, always ready) writes the five
//   registers; write only while no event is in flight.
//   a taken word is registered in the input stage, evaluated there and,
//   once the result register is free or draining, shown on the result ports.
//   throughput: one event per cycle while the result is not stalled; the
//   station update and the parallel key table compare are both combinational.
//   reset clears the counts, the table valid bits and the registers to
//   their defaults, window back to 15; no clearing pass is needed.
//   a stalled result holds; item_stall rises once the input stage is full
//   behind a stalled result.
// ----------------------------------------------------------------------------
`include "wlan_retry_and_backoff_window_core_macros.svh"

module wlan_retry_and_backoff_window_core
    import wrbw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [OP_BITS-1:0]       opcode,
    input  logic [ID_BITS-1:0]       frame_id,
    input  logic [LEN_BITS-1:0]      frame_length,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [CW_BITS-1:0]       contention_window,
    output logic                     limit_reached,
    output logic                     entry_missing,
    output logic                     table_full,
    output logic [CNT_BITS-1:0]      station_short_count,
    output logic [CNT_BITS-1:0]      station_long_count,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t                cfg;
    logic                stage_v_reg;
    logic                stage_v_next;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_BITS-1:0] len_reg;
    logic                res_v_reg;
    logic                res_v_next;
    logic                advance;
    logic                fire;
    logic                take;
    logic                is_long;
    tbl_req_t            tbl_req;
    tbl_rsp_t            tbl_rsp;
    logic [CW_BITS-1:0]  window_after;
    logic [CNT_BITS-1:0] short_after;
    logic [CNT_BITS-1:0] long_after;

    logic [CW_BITS-1:0]  cw_reg;
    logic                lim_reg;
    logic                miss_reg;
    logic                full_reg;
    logic [CNT_BITS-1:0] ssc_reg;
    logic [CNT_BITS-1:0] slc_reg;

    wrbw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result register free or being drained this cycle
    assign advance    = !res_v_reg || !result_stall;
    assign fire       = stage_v_reg && advance;
    assign item_stall = stage_v_reg && !advance;
    assign take       = item_valid && !item_stall;
    assign is_long    = (len_reg >= cfg.rts_threshold);

    assign stage_v_next = take || (stage_v_reg && !advance);
    assign res_v_next   = fire || (res_v_reg && result_stall);

    assign tbl_req.fire    = fire;
    assign tbl_req.op      = op_reg;
    assign tbl_req.is_long = is_long;
    assign tbl_req.key     = key_reg;

    wrbw_station u_station (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .fire         (fire),
        .op           (op_reg),
        .is_long      (is_long),
        .window_after (window_after),
        .short_after  (short_after),
        .long_after   (long_after)
    );

    wrbw_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
            res_v_reg   <= 1'b0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
            res_v_reg   <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= op_t'(opcode);
            key_reg <= frame_id[KEY_W-1:0];
            len_reg <= frame_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cw_reg   <= window_after;
            lim_reg  <= tbl_rsp.limit_reached;
            miss_reg <= tbl_rsp.entry_missing;
            full_reg <= tbl_rsp.table_full;
            ssc_reg  <= short_after;
            slc_reg  <= long_after;
        end
    end

    assign result_valid        = res_v_reg;
    assign contention_window   = cw_reg;
    assign limit_reached       = lim_reg;
    assign entry_missing       = miss_reg;
    assign table_full          = full_reg;
    assign station_short_count = ssc_reg;
    assign station_long_count  = slc_reg;

    `WRBW_ASSERT_NOW(a_stall_needs_word, item_stall, stage_v_reg && res_v_reg && result_stall, "stall without a held word")
    `WRBW_ASSERT_NEXT(a_fire_gives_result, fire, res_v_reg, "evaluated word did not reach the result register")

endmodule
